// ===== design/dasc_pkg.sv =====
// ----------------------------------------------------------------------------
// dasc_pkg
// Shared types and constants for the audio sample dma channel.
// ----------------------------------------------------------------------------
package dasc_pkg;

    localparam int RAM_BYTES_DEF = 65536;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int ADDR_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_ENABLE  = 3'd0,
        REG_LOOP_ENABLE     = 3'd1,
        REG_SAMPLE_FORMAT   = 3'd2,
        REG_BEGIN_ADDRESS   = 3'd3,
        REG_INITIAL_ADDRESS = 3'd4,
        REG_LIMIT_ADDRESS   = 3'd5,
        REG_RATE_STEP       = 3'd6,
        REG_VOLUME          = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FMT_LO_NIBBLE = 2'd0,
        FMT_HI_NIBBLE = 2'd1,
        FMT_BYTE      = 2'd2,
        FMT_WORD      = 2'd3
    } fmt_t;

    typedef enum logic {
        OP_TICK      = 1'b0,
        OP_RAM_WRITE = 1'b1
    } opcode_t;

    typedef struct packed {
        logic        opcode;
        logic [15:0] ram_address;
        logic [7:0]  ram_data;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               fetched;
        logic               stopped;
        logic [ADDR_W-1:0]  current_address;
    } out_item_t;

    // per-item control that travels with the sample through the gain pipeline
    typedef struct packed {
        logic              fetched;
        logic              use_data;
        logic              clr;
        fmt_t              fmt;
        logic              stopped;
        logic [ADDR_W-1:0] address;
    } ctrl_t;

endpackage

// ===== design/dasc_ram.sv =====
// ----------------------------------------------------------------------------
// dasc_ram
// Generic synchronous ram, one write port, two registered read ports.
// ----------------------------------------------------------------------------
module dasc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                       rdata_a,
    output logic [WIDTH-1:0]                       rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== design/dasc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dasc_ctrl
// Configuration registers, phase accumulator, fetch address and stop flag;
// issues sample ram writes for accepted in-range write items and a read for each accepted item.
// ----------------------------------------------------------------------------
module dasc_ctrl #(
    parameter int RAM_BYTES = dasc_pkg::RAM_BYTES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  dasc_pkg::in_item_t                    in_item,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dasc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dasc_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  stage_take,
    output logic                                  ctrl_valid,
    output dasc_pkg::ctrl_t                       ctrl,
    output logic [7:0]                            vol,
    output logic                                  ram_we,
    output logic [((RAM_BYTES > 1) ? $clog2(RAM_BYTES) : 1)-1:0] ram_waddr,
    output logic [7:0]                            ram_wdata,
    output logic                                  ram_re,
    output logic [((RAM_BYTES > 1) ? $clog2(RAM_BYTES) : 1)-1:0] ram_raddr_a,
    output logic [((RAM_BYTES > 1) ? $clog2(RAM_BYTES) : 1)-1:0] ram_raddr_b
);

    import dasc_pkg::*;

    localparam int AW = (RAM_BYTES > 1) ? $clog2(RAM_BYTES) : 1;
    localparam logic [ADDR_W:0] RAM_SIZE = (ADDR_W + 1)'(RAM_BYTES);
    localparam logic [ADDR_W:0] RAM_LAST = (ADDR_W + 1)'(RAM_BYTES - 1);

    logic              en_reg;
    logic              loop_reg;
    fmt_t              fmt_reg;
    logic [ADDR_W-1:0] begin_reg;
    logic [ADDR_W-1:0] init_reg;
    logic [15:0]       limit_reg;
    logic [ADDR_W-1:0] rate_reg;
    logic [7:0]        vol_reg;

    logic [ADDR_W-1:0] acc_reg;
    logic [ADDR_W-1:0] acc_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    logic              stop_reg;
    logic              stop_next;
    logic              valid_reg;
    logic              valid_next;
    ctrl_t             ctrl_reg;
    ctrl_t             ctrl_next;

    logic              accept;
    logic              free;
    logic              cfg_fire;
    logic [ADDR_W:0]   sum;
    logic [ADDR_W-1:0] adv;
    logic [ADDR_W-1:0] addr_plus1;
    logic              silent;
    logic              limit_hit;
    logic              ram_ok;
    logic [ADDR_W-1:0] waddr_ext;

    assign free      = !valid_reg || stage_take;
    assign in_stall  = !free;
    assign accept    = in_valid && free;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;

    assign sum        = {1'b0, acc_reg} + {1'b0, rate_reg};
    assign adv        = addr_reg + ((fmt_reg == FMT_WORD) ? ADDR_W'(2) : ADDR_W'(1));
    assign addr_plus1 = addr_reg + ADDR_W'(1);
    assign silent     = {1'b0, addr_reg} >= RAM_LAST;
    assign limit_hit  = adv[15:0] == limit_reg;

    assign ram_ok    = {{(ADDR_W - 15){1'b0}}, in_item.ram_address} < RAM_SIZE;
    assign waddr_ext = {{(ADDR_W - 16){1'b0}}, in_item.ram_address};

    assign ram_we      = accept && (in_item.opcode == OP_RAM_WRITE) && ram_ok;
    assign ram_waddr   = waddr_ext[AW-1:0];
    assign ram_wdata   = in_item.ram_data;
    assign ram_re      = accept;
    assign ram_raddr_a = addr_reg[AW-1:0];
    assign ram_raddr_b = addr_plus1[AW-1:0];

    always_comb
    begin
        acc_next  = acc_reg;
        addr_next = addr_reg;
        stop_next = stop_reg;
        ctrl_next.fetched  = 1'b0;
        ctrl_next.use_data = 1'b0;
        ctrl_next.clr      = 1'b0;
        ctrl_next.fmt      = fmt_reg;
        if (cfg_fire)
        begin
            addr_next = (cfg_reg_t'(cfg_index) == REG_INITIAL_ADDRESS) ? cfg_data : init_reg;
            stop_next = 1'b0;
            acc_next  = '0;
        end
        else if (accept && (in_item.opcode == OP_TICK))
        begin
            if (!en_reg || stop_reg)
            begin
                acc_next      = '0;
                ctrl_next.clr = 1'b1;
            end
            else if (sum[ADDR_W])
            begin
                acc_next           = sum[ADDR_W-1:0];
                addr_next          = adv;
                ctrl_next.fetched  = 1'b1;
                ctrl_next.use_data = !silent;
                ctrl_next.clr      = silent;
                if (limit_hit)
                begin
                    if (loop_reg)
                    begin
                        addr_next = begin_reg;
                    end
                    else
                    begin
                        stop_next          = 1'b1;
                        acc_next           = '0;
                        ctrl_next.use_data = 1'b0;
                        ctrl_next.clr      = 1'b1;
                    end
                end
            end
            else
            begin
                acc_next = sum[ADDR_W-1:0];
            end
        end
        ctrl_next.stopped = stop_next;
        ctrl_next.address = addr_next;
    end

    assign valid_next = accept || (valid_reg && !stage_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg    <= 1'b0;
            loop_reg  <= 1'b0;
            fmt_reg   <= FMT_LO_NIBBLE;
            begin_reg <= '0;
            init_reg  <= '0;
            limit_reg <= '0;
            rate_reg  <= '0;
            vol_reg   <= '0;
            acc_reg   <= '0;
            addr_reg  <= '0;
            stop_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            addr_reg  <= addr_next;
            stop_reg  <= stop_next;
            valid_reg <= valid_next;
            if (cfg_fire)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_CHANNEL_ENABLE:  en_reg    <= cfg_data[0];
                    REG_LOOP_ENABLE:     loop_reg  <= cfg_data[0];
                    REG_SAMPLE_FORMAT:   fmt_reg   <= fmt_t'(cfg_data[1:0]);
                    REG_BEGIN_ADDRESS:   begin_reg <= cfg_data;
                    REG_INITIAL_ADDRESS: init_reg  <= cfg_data;
                    REG_LIMIT_ADDRESS:   limit_reg <= cfg_data[15:0];
                    REG_RATE_STEP:       rate_reg  <= cfg_data;
                    REG_VOLUME:          vol_reg   <= cfg_data[7:0];
                    default:             en_reg    <= en_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    assign ctrl_valid = valid_reg;
    assign ctrl       = ctrl_reg;
    assign vol        = vol_reg;

endmodule

// ===== design/dasc_gain.sv =====
// ----------------------------------------------------------------------------
// dasc_gain
// Sample format decode, volume scaling by volume/255 toward zero, held
// sample and output register.
// ----------------------------------------------------------------------------
module dasc_gain (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                take,
    input  dasc_pkg::ctrl_t     ctrl,
    input  logic [7:0]          vol,
    input  logic [7:0]          d0,
    input  logic [7:0]          d1,
    output logic                out_valid,
    input  logic                out_stall,
    output dasc_pkg::out_item_t out_item
);

    import dasc_pkg::*;

    // floor(2^24 / 255), quotient is m/255 or one below before correction
    localparam logic [16:0] RECIP_255 = 17'h10101;
    localparam logic [23:0] DIV_255   = 24'd255;

    logic        v2_reg;
    logic [23:0] m2_reg;
    logic        neg2_reg;
    ctrl_t       c2_reg;

    logic        v3_reg;
    logic [23:0] m3_reg;
    logic        neg3_reg;
    logic [15:0] q3_reg;
    ctrl_t       c3_reg;

    logic        vo_reg;
    logic [15:0] held_reg;
    logic [15:0] held_next;
    ctrl_t       co_reg;

    logic        ld2;
    logic        ld3;
    logic        ldo;

    logic [15:0] raw;
    logic        neg;
    logic [15:0] mag;
    logic [23:0] m_prod;
    logic [40:0] recip_full;
    logic [23:0] rem;
    logic [15:0] quo;
    logic [15:0] scaled;

    assign ldo  = v3_reg && (!vo_reg || !out_stall);
    assign ld3  = v2_reg && (!v3_reg || ldo);
    assign take = !v2_reg || ld3;
    assign ld2  = in_valid && take;

    always_comb
    begin
        case (ctrl.fmt)
            FMT_LO_NIBBLE: raw = {d0[3:0], 12'h000};
            FMT_HI_NIBBLE: raw = {d0[7:4], 12'h000};
            FMT_BYTE:      raw = {d0, 8'h00};
            FMT_WORD:      raw = {d1, d0};
            default:       raw = {d1, d0};
        endcase
    end

    assign neg    = raw[15];
    assign mag    = neg ? (~raw + 16'd1) : raw;
    assign m_prod = {8'h00, mag} * {16'h0000, vol};

    assign recip_full = {17'h00000, m2_reg} * {24'h000000, RECIP_255};

    assign rem    = m3_reg - {q3_reg, 8'h00} + {8'h00, q3_reg};
    assign quo    = q3_reg + ((rem >= DIV_255) ? 16'd1 : 16'd0);
    assign scaled = neg3_reg ? (~quo + 16'd1) : quo;

    always_comb
    begin
        held_next = held_reg;
        if (c3_reg.use_data)
        begin
            held_next = scaled;
        end
        else if (c3_reg.clr)
        begin
            held_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vo_reg   <= 1'b0;
            held_reg <= '0;
        end
        else
        begin
            v2_reg <= ld2 || (v2_reg && !ld3);
            v3_reg <= ld3 || (v3_reg && !ldo);
            vo_reg <= ldo || (vo_reg && out_stall);
            if (ldo)
            begin
                held_reg <= held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            m2_reg   <= m_prod;
            neg2_reg <= neg;
            c2_reg   <= ctrl;
        end
        if (ld3)
        begin
            m3_reg   <= m2_reg;
            neg3_reg <= neg2_reg;
            q3_reg   <= recip_full[39:24];
            c3_reg   <= c2_reg;
        end
        if (ldo)
        begin
            co_reg <= c3_reg;
        end
    end

    assign out_valid                = vo_reg;
    assign out_item.sample_out      = $signed(held_reg);
    assign out_item.fetched         = co_reg.fetched;
    assign out_item.stopped         = co_reg.stopped;
    assign out_item.current_address = co_reg.address;

endmodule

// ===== design/dma_audio_sample_channel_top.sv =====
// ----------------------------------------------------------------------------
// dma_audio_sample_channel_top
// One audio dma channel: phase accumulator, sample ram fetch and volume gain.
// Throughput: one item per cycle unless out_stall holds the pipeline; a word fetch reads both bytes through the
// two read ports of the sample ram in the same cycle.
// Reset: clears configuration, accumulator, address, stop flag and held
// sample; the sample ram is not cleared and must be loaded before playback.
// ----------------------------------------------------------------------------
module dma_audio_sample_channel_top #(
    parameter int RAM_BYTES = dasc_pkg::RAM_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  dasc_pkg::in_item_t              in_item,
    output logic                            out_valid,
    input  logic                            out_stall,
    output dasc_pkg::out_item_t             out_item,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dasc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dasc_pkg::CFG_DATA_W-1:0] cfg_data
);

    import dasc_pkg::*;

    localparam int AW = (RAM_BYTES > 1) ? $clog2(RAM_BYTES) : 1;

    logic          stage_take;
    logic          ctrl_valid;
    ctrl_t         ctrl;
    logic [7:0]    vol;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr_a;
    logic [AW-1:0] ram_raddr_b;
    logic [7:0]    ram_rdata_a;
    logic [7:0]    ram_rdata_b;

    dasc_ctrl #(
        .RAM_BYTES (RAM_BYTES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .stage_take  (stage_take),
        .ctrl_valid  (ctrl_valid),
        .ctrl        (ctrl),
        .vol         (vol),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr_a (ram_raddr_a),
        .ram_raddr_b (ram_raddr_b)
    );

    dasc_ram #(
        .WIDTH (8),
        .DEPTH (RAM_BYTES)
    ) u_sample_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (ram_re),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    dasc_gain u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ctrl_valid),
        .take      (stage_take),
        .ctrl      (ctrl),
        .vol       (vol),
        .d0        (ram_rdata_a),
        .d1        (ram_rdata_b),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
